// File: src/kvt_pkg.sv
// shared types and constants for the key/value line tokenizer
package kvt_pkg;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] CaseGap  = 8'h20;

  localparam int unsigned KindW   = 3;
  localparam int unsigned CharW   = 8;
  localparam int unsigned SpacesW = 8;

  localparam logic [KindW-1:0] KindNameChar    = 3'd0;
  localparam logic [KindW-1:0] KindValueChar   = 3'd1;
  localparam logic [KindW-1:0] KindPairDone    = 3'd2;
  localparam logic [KindW-1:0] KindNameDropped = 3'd3;
  localparam logic [KindW-1:0] KindNoPair      = 3'd4;

  typedef enum logic [2:0] {
    ClsNul,
    ClsBlank,
    ClsEol,
    ClsHash,
    ClsEquals,
    ClsOther
  } char_class_e;

  typedef struct packed {
    logic             eoi;
    char_class_e      cls;
    logic [CharW-1:0] ch;
    logic [CharW-1:0] ch_lower;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// File: src/kvt_if.sv
// handshake channels for the tokenizer input bytes and output tokens
interface kvt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink (input valid, input func, input in_byte, output ready);
endinterface

interface kvt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_char;
  logic [7:0] spaces_before;

  modport source (output valid, output kind, output out_char, output spaces_before,
                  input ready);
  modport sink (input valid, input kind, input out_char, input spaces_before,
                output ready);
endinterface

// File: src/kvt_front.sv
// front end: accepts input bytes, classifies them and queues them for the back end
module kvt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  kvt_in_if.sink        in_i,
  input  logic          pop_i,
  output kvt_pkg::head_t head_o
);

  kvt_pkg::item_t item_in;
  kvt_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  // classify the incoming byte
  always_comb begin
    item_in.eoi = in_i.func;
    item_in.ch  = in_i.in_byte;
    if (in_i.in_byte >= kvt_pkg::ChUpperA && in_i.in_byte <= kvt_pkg::ChUpperZ) begin
      item_in.ch_lower = in_i.in_byte + kvt_pkg::CaseGap;
    end else begin
      item_in.ch_lower = in_i.in_byte;
    end
    priority if (in_i.in_byte == kvt_pkg::ChNul) begin
      item_in.cls = kvt_pkg::ClsNul;
    end else if (in_i.in_byte == kvt_pkg::ChSpace || in_i.in_byte == kvt_pkg::ChTab) begin
      item_in.cls = kvt_pkg::ClsBlank;
    end else if (in_i.in_byte == kvt_pkg::ChLf || in_i.in_byte == kvt_pkg::ChCr) begin
      item_in.cls = kvt_pkg::ClsEol;
    end else if (in_i.in_byte == kvt_pkg::ChHash) begin
      item_in.cls = kvt_pkg::ClsHash;
    end else if (in_i.in_byte == kvt_pkg::ChEquals) begin
      item_in.cls = kvt_pkg::ClsEquals;
    end else begin
      item_in.cls = kvt_pkg::ClsOther;
    end
  end

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// File: src/kvt_back.sv
// back end: line parsing state machine and registered token output
module kvt_back #(
  parameter int unsigned SPACE_COUNT_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kvt_pkg::head_t head_i,
  output logic          pop_o,
  kvt_out_if.source     out_o
);

  localparam logic [2:0] ModeSkip    = 3'd0;
  localparam logic [2:0] ModeComment = 3'd1;
  localparam logic [2:0] ModeName    = 3'd2;
  localparam logic [2:0] ModeDelim   = 3'd3;
  localparam logic [2:0] ModeValue   = 3'd4;

  localparam int unsigned WideW =
    (SPACE_COUNT_BITS > kvt_pkg::SpacesW) ? SPACE_COUNT_BITS : kvt_pkg::SpacesW;

  logic [2:0]                  mode_q, mode_d;
  logic                        eq_q, eq_d;
  logic [SPACE_COUNT_BITS-1:0] pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  logic [kvt_pkg::KindW-1:0]   kind_q, kind_d;
  logic [kvt_pkg::CharW-1:0]   char_q, char_d;
  logic [kvt_pkg::SpacesW-1:0] sp_q, sp_d;
  logic                        take, emit;
  logic [WideW-1:0]            pend_ext;
  logic [kvt_pkg::SpacesW-1:0] pend_sat;
  kvt_pkg::item_t              it;

  assign it    = head_i.item;
  assign take  = head_i.valid && (!out_valid_q || out_o.ready);
  assign pop_o = take;

  // clamp the held blank count to the output width
  assign pend_ext = WideW'(pend_q);
  assign pend_sat = (pend_ext > WideW'({kvt_pkg::SpacesW{1'b1}})) ?
                    {kvt_pkg::SpacesW{1'b1}} : pend_ext[kvt_pkg::SpacesW-1:0];

  always_comb begin
    mode_d = mode_q;
    eq_d   = eq_q;
    pend_d = pend_q;
    emit   = 1'b0;
    kind_d = kind_q;
    char_d = char_q;
    sp_d   = sp_q;
    if (take) begin
      char_d = '0;
      sp_d   = '0;
      if (it.eoi) begin
        emit   = 1'b1;
        kind_d = (mode_q == ModeValue) ? kvt_pkg::KindPairDone : kvt_pkg::KindNoPair;
        mode_d = ModeSkip;
        eq_d   = 1'b0;
        pend_d = '0;
      end else begin
        unique case (mode_q)
          ModeComment: begin
            if (it.cls == kvt_pkg::ClsEol) begin
              mode_d = ModeSkip;
              eq_d   = 1'b0;
              pend_d = '0;
            end
          end
          ModeName: begin
            unique case (it.cls)
              kvt_pkg::ClsNul: ;
              kvt_pkg::ClsEol: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindNameDropped;
                mode_d = ModeSkip;
                eq_d   = 1'b0;
                pend_d = '0;
              end
              kvt_pkg::ClsBlank, kvt_pkg::ClsEquals: begin
                mode_d = ModeDelim;
                eq_d   = 1'b0;
              end
              default: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindNameChar;
                char_d = it.ch_lower;
              end
            endcase
          end
          ModeDelim: begin
            unique case (it.cls)
              kvt_pkg::ClsNul, kvt_pkg::ClsBlank: ;
              kvt_pkg::ClsEol: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindNameDropped;
                mode_d = ModeSkip;
                eq_d   = 1'b0;
                pend_d = '0;
              end
              kvt_pkg::ClsEquals: begin
                eq_d = 1'b1;
                if (eq_q) begin
                  emit   = 1'b1;
                  kind_d = kvt_pkg::KindValueChar;
                  char_d = it.ch;
                  mode_d = ModeValue;
                  pend_d = '0;
                end
              end
              default: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindValueChar;
                char_d = it.ch;
                mode_d = ModeValue;
                pend_d = '0;
              end
            endcase
          end
          ModeValue: begin
            unique case (it.cls)
              kvt_pkg::ClsNul: ;
              kvt_pkg::ClsEol: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindPairDone;
                mode_d = ModeSkip;
                eq_d   = 1'b0;
                pend_d = '0;
              end
              kvt_pkg::ClsBlank: begin
                if (pend_q != {SPACE_COUNT_BITS{1'b1}}) begin
                  pend_d = pend_q + SPACE_COUNT_BITS'(1);
                end
              end
              default: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindValueChar;
                char_d = it.ch;
                sp_d   = pend_sat;
                pend_d = '0;
              end
            endcase
          end
          default: begin
            // skip blanks, and any unused mode code
            mode_d = ModeSkip;
            unique case (it.cls)
              kvt_pkg::ClsNul, kvt_pkg::ClsBlank, kvt_pkg::ClsEol: ;
              kvt_pkg::ClsHash: mode_d = ModeComment;
              default: begin
                emit   = 1'b1;
                kind_d = kvt_pkg::KindNameChar;
                char_d = it.ch_lower;
                mode_d = ModeName;
              end
            endcase
          end
        endcase
      end
    end
    out_valid_d = (out_valid_q && !out_o.ready) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeSkip;
      eq_q        <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      eq_q        <= eq_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      char_q <= char_d;
      sp_q   <= sp_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.out_char      = char_q;
  assign out_o.spaces_before = sp_q;

endmodule

// File: src/key_value_line_tokenizer.sv
// top level of the key/value line tokenizer
// Takes one byte (or an end-of-input marker) per transaction and sustains one
// transaction per clock cycle while the output side accepts tokens. A result
// passes through the two-entry queue of the front end and then the output
// register of the parsing state machine. Input ready drops only when the queue
// is full, which happens when the output side stalls. Blanks inside a value are
// counted in SPACE_COUNT_BITS bits and reported, clamped to 255, with the next
// visible value character.
module key_value_line_tokenizer #(
  parameter int unsigned SPACE_COUNT_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kvt_in_if.sink    in_i,
  kvt_out_if.source out_o
);

  kvt_pkg::head_t head;
  logic           pop;

  kvt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  kvt_back #(
    .SPACE_COUNT_BITS (SPACE_COUNT_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// File: src/kvt_checker.sv
// port-level checks for the key/value line tokenizer
module kvt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [kvt_pkg::KindW-1:0]     kind_i,
  input logic [kvt_pkg::CharW-1:0]     out_char_i,
  input logic [kvt_pkg::SpacesW-1:0]   spaces_before_i
);

  // stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(out_char_i) && $stable(spaces_before_i))
    else $error("output token changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i <= kvt_pkg::KindNoPair)
    else $error("token kind out of range");

  // only value characters carry blanks
  a_spaces_value_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != kvt_pkg::KindValueChar |-> spaces_before_i == '0)
    else $error("blank count on a non-value token");

  a_marker_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != kvt_pkg::KindValueChar && kind_i != kvt_pkg::KindNameChar
      |-> out_char_i == '0)
    else $error("character on an end marker token");

endmodule

bind key_value_line_tokenizer kvt_checker u_kvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .kind_i          (out_o.kind),
  .out_char_i      (out_o.out_char),
  .spaces_before_i (out_o.spaces_before)
);

// File: bench/tb_top.sv
// self-checking testbench for the key/value line tokenizer: directed table, then random text
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems  = 1550;
  localparam int QuietTail   = 200;
  localparam int LongHold    = 80;
  localparam int CycleLimit  = 200000;
  localparam int NumDirected = 26;

  typedef enum logic [2:0] {
    ScanSkip,
    ScanComment,
    ScanName,
    ScanDelim,
    ScanValue
  } scan_mode_e;

  typedef struct packed {
    logic [kvt_pkg::KindW-1:0]   kind;
    logic [kvt_pkg::CharW-1:0]   ch;
    logic [kvt_pkg::SpacesW-1:0] spaces;
  } token_t;

  typedef struct packed {
    logic                      eoi;
    logic [kvt_pkg::CharW-1:0] c;
    logic                      pinned;
    token_t                    tok;
  } stim_row_t;

  localparam token_t NoToken = '{kvt_pkg::KindNameChar, 8'h00, 8'h00};

  // pinned rows carry the token read straight off the behaviour, the rest are predicted
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{1'b1, 8'hA5,             1'b1, '{kvt_pkg::KindNoPair, 8'h00, 8'h00}},
    '{1'b0, 8'h41,             1'b1, '{kvt_pkg::KindNameChar, 8'h61, 8'h00}},
    '{1'b0, 8'h5A,             1'b1, '{kvt_pkg::KindNameChar, 8'h7A, 8'h00}},
    '{1'b0, 8'hFF,             1'b1, '{kvt_pkg::KindNameChar, 8'hFF, 8'h00}},
    '{1'b0, kvt_pkg::ChNul,    1'b0, NoToken},
    '{1'b0, kvt_pkg::ChEquals, 1'b0, NoToken},
    '{1'b0, kvt_pkg::ChSpace,  1'b0, NoToken},
    '{1'b0, kvt_pkg::ChEquals, 1'b0, NoToken},
    '{1'b0, kvt_pkg::ChEquals, 1'b1, '{kvt_pkg::KindValueChar, kvt_pkg::ChEquals, 8'h00}},
    '{1'b0, kvt_pkg::ChTab,    1'b0, NoToken},
    '{1'b0, kvt_pkg::ChSpace,  1'b0, NoToken},
    '{1'b0, 8'h80,             1'b1, '{kvt_pkg::KindValueChar, 8'h80, 8'd2}},
    '{1'b0, kvt_pkg::ChSpace,  1'b0, NoToken},
    '{1'b0, kvt_pkg::ChCr,     1'b1, '{kvt_pkg::KindPairDone, 8'h00, 8'h00}},
    '{1'b0, kvt_pkg::ChHash,   1'b0, NoToken},
    '{1'b0, 8'h71,             1'b0, NoToken},
    '{1'b0, kvt_pkg::ChLf,     1'b0, NoToken},
    '{1'b0, 8'h7F,             1'b0, NoToken},
    '{1'b0, kvt_pkg::ChLf,     1'b1, '{kvt_pkg::KindNameDropped, 8'h00, 8'h00}},
    '{1'b0, 8'h6D,             1'b0, NoToken},
    '{1'b0, kvt_pkg::ChTab,    1'b0, NoToken},
    '{1'b0, kvt_pkg::ChCr,     1'b1, '{kvt_pkg::KindNameDropped, 8'h00, 8'h00}},
    '{1'b0, 8'h4E,             1'b0, NoToken},
    '{1'b0, kvt_pkg::ChSpace,  1'b0, NoToken},
    '{1'b0, 8'h76,             1'b0, NoToken},
    '{1'b1, 8'h5A,             1'b1, '{kvt_pkg::KindPairDone, 8'h00, 8'h00}}
  };

  logic clk;
  logic rst_n;

  kvt_in_if  in_ch ();
  kvt_out_if out_ch ();

  key_value_line_tokenizer #(
    .SPACE_COUNT_BITS(8)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  scan_mode_e                  scan_mode;
  logic                        equals_taken;
  logic [kvt_pkg::SpacesW-1:0] held_blanks;

  token_t tokens_due [$];
  int     errors;
  int     items_sent;
  bit     idle_bursts;
  bit     stall_bursts;
  bit     long_hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_scan();
    scan_mode    = ScanSkip;
    equals_taken = 1'b0;
    held_blanks  = '0;
  endfunction

  function automatic logic [kvt_pkg::CharW-1:0] fold_case(
    input logic [kvt_pkg::CharW-1:0] c);
    return (c >= kvt_pkg::ChUpperA && c <= kvt_pkg::ChUpperZ) ? c + kvt_pkg::CaseGap : c;
  endfunction

  function automatic bit tokenize_byte(input logic eoi,
                                       input logic [kvt_pkg::CharW-1:0] c,
                                       output token_t tok);
    bit eol;
    bit blank;
    bit hit;
    eol   = (c == kvt_pkg::ChLf) || (c == kvt_pkg::ChCr);
    blank = (c == kvt_pkg::ChSpace) || (c == kvt_pkg::ChTab);
    tok   = NoToken;
    hit   = 1'b0;
    if (eoi) begin
      tok.kind = (scan_mode == ScanValue) ? kvt_pkg::KindPairDone : kvt_pkg::KindNoPair;
      hit = 1'b1;
      clear_scan();
    end else begin
      case (scan_mode)
        ScanComment: begin
          if (eol) scan_mode = ScanSkip;
        end
        ScanName: begin
          if (eol) begin
            tok.kind = kvt_pkg::KindNameDropped;
            hit = 1'b1;
            clear_scan();
          end else if (blank || c == kvt_pkg::ChEquals) begin
            scan_mode    = ScanDelim;
            equals_taken = 1'b0;
          end else if (c != kvt_pkg::ChNul) begin
            tok.ch = fold_case(c);
            hit = 1'b1;
          end
        end
        ScanDelim: begin
          if (eol) begin
            tok.kind = kvt_pkg::KindNameDropped;
            hit = 1'b1;
            clear_scan();
          end else if (c == kvt_pkg::ChEquals && !equals_taken) begin
            equals_taken = 1'b1;
          end else if (c != kvt_pkg::ChNul && !blank) begin
            scan_mode   = ScanValue;
            held_blanks = '0;
            tok.kind    = kvt_pkg::KindValueChar;
            tok.ch      = c;
            hit = 1'b1;
          end
        end
        ScanValue: begin
          if (eol) begin
            tok.kind = kvt_pkg::KindPairDone;
            hit = 1'b1;
            clear_scan();
          end else if (blank) begin
            if (held_blanks != '1) held_blanks++;
          end else if (c != kvt_pkg::ChNul) begin
            tok.kind    = kvt_pkg::KindValueChar;
            tok.ch      = c;
            tok.spaces  = held_blanks;
            held_blanks = '0;
            hit = 1'b1;
          end
        end
        default: begin
          scan_mode = ScanSkip;
          if (c == kvt_pkg::ChHash) begin
            scan_mode = ScanComment;
          end else if (!(c == kvt_pkg::ChNul || blank || eol)) begin
            scan_mode = ScanName;
            tok.ch = fold_case(c);
            hit = 1'b1;
          end
        end
      endcase
    end
    return hit;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic eoi, input logic [kvt_pkg::CharW-1:0] c,
                           input logic pinned, input token_t want);
    token_t pred;
    bit     hit;
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      in_ch.valid   = 1'b0;
      in_ch.func    = 1'($urandom);
      in_ch.in_byte = 8'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = eoi;
    in_ch.in_byte = c;
    do @(posedge clk); while (!in_ch.ready);
    hit = tokenize_byte(eoi, c, pred);
    if (pinned) tokens_due.push_back(want);
    else if (hit) tokens_due.push_back(pred);
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_data(input logic [kvt_pkg::CharW-1:0] c);
    send_item(1'b0, c, 1'b0, NoToken);
  endtask

  task automatic send_end();
    send_item(1'b1, 8'($urandom), 1'b0, NoToken);
  endtask

  task automatic send_blanks(input int n);
    repeat (n) send_data($urandom_range(0, 1) ? kvt_pkg::ChTab : kvt_pkg::ChSpace);
  endtask

  task automatic send_eol();
    send_data($urandom_range(0, 1) ? kvt_pkg::ChLf : kvt_pkg::ChCr);
  endtask

  function automatic logic [kvt_pkg::CharW-1:0] pick_plain(input bit allow_eq,
                                                           input bit allow_hash);
    logic [kvt_pkg::CharW-1:0] c;
    do begin
      if ($urandom_range(0, 1))
        c = kvt_pkg::ChUpperA + 8'($urandom_range(0, 25)) +
            ($urandom_range(0, 1) ? kvt_pkg::CaseGap : 8'h00);
      else
        c = 8'($urandom);
    end while (c == kvt_pkg::ChNul || c == kvt_pkg::ChTab || c == kvt_pkg::ChLf ||
               c == kvt_pkg::ChCr || c == kvt_pkg::ChSpace ||
               (!allow_eq && c == kvt_pkg::ChEquals) ||
               (!allow_hash && c == kvt_pkg::ChHash));
    return c;
  endfunction

  task automatic send_pair(input int long_gap);
    int gap;
    int words;
    send_blanks($urandom_range(0, 2));
    send_data(pick_plain(1'b0, 1'b0));
    repeat ($urandom_range(0, 7)) begin
      if ($urandom_range(0, 19) == 0) send_data(kvt_pkg::ChNul);
      send_data(pick_plain(1'b0, 1'b1));
    end
    case ($urandom_range(0, 3))
      0: send_blanks($urandom_range(1, 3));
      1: send_data(kvt_pkg::ChEquals);
      2: begin
        send_blanks($urandom_range(1, 2));
        send_data(kvt_pkg::ChEquals);
        send_blanks($urandom_range(0, 2));
      end
      default: begin
        repeat ($urandom_range(2, 3)) begin
          send_data(kvt_pkg::ChEquals);
          send_blanks($urandom_range(0, 1));
        end
      end
    endcase
    send_data(pick_plain(1'b1, 1'b1));
    words = (long_gap > 0) ? 1 : $urandom_range(0, 6);
    repeat (words) begin
      if (long_gap > 0) gap = long_gap;
      else if ($urandom_range(0, 59) == 0) gap = $urandom_range(250, 300);
      else gap = $urandom_range(0, 3);
      long_gap = 0;
      send_blanks(gap);
      if ($urandom_range(0, 19) == 0) send_data(kvt_pkg::ChNul);
      send_data(pick_plain(1'b1, 1'b1));
    end
    send_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) send_end();
    else send_eol();
  endtask

  task automatic send_line();
    int                        r;
    logic [kvt_pkg::CharW-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_pair(0);
    end else if (r < 70) begin
      send_blanks($urandom_range(0, 1));
      send_data(kvt_pkg::ChHash);
      repeat ($urandom_range(0, 10)) begin
        do c = 8'($urandom); while (c == kvt_pkg::ChLf || c == kvt_pkg::ChCr);
        send_data(c);
      end
      if ($urandom_range(0, 4) == 0) send_end();
      else send_eol();
    end else if (r < 80) begin
      // name with no value
      send_data(pick_plain(1'b0, 1'b0));
      repeat ($urandom_range(0, 4)) send_data(pick_plain(1'b0, 1'b1));
      case ($urandom_range(0, 2))
        0: send_blanks($urandom_range(1, 2));
        1: send_data(kvt_pkg::ChEquals);
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) send_end();
      else send_eol();
    end else if (r < 88) begin
      send_blanks($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) send_data(kvt_pkg::ChNul);
      send_eol();
    end else begin
      repeat ($urandom_range(1, 8)) send_data(8'($urandom));
      if ($urandom_range(0, 3) == 0) send_end();
    end
  endtask

  task automatic wait_drained();
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    int held;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready = 1'b0;
        held = 0;
        while (held < LongHold) begin
          @(negedge clk);
          held++;
        end
        long_hold_req = 1'b0;
      end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none, got kind %0d char %02h spaces %0d",
                 $realtime, out_ch.kind, out_ch.out_char, out_ch.spaces_before);
      end else begin
        want = tokens_due.pop_front();
        if (out_ch.kind !== want.kind) begin
          errors++;
          $display("%0t: kind: expected %0d, got %0d", $realtime, want.kind, out_ch.kind);
        end
        if (out_ch.out_char !== want.ch) begin
          errors++;
          $display("%0t: out_char: expected %02h, got %02h", $realtime, want.ch,
                   out_ch.out_char);
        end
        if (out_ch.spaces_before !== want.spaces) begin
          errors++;
          $display("%0t: spaces_before: expected %0d, got %0d", $realtime, want.spaces,
                   out_ch.spaces_before);
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit hold_done;
    bit pause_done;
    in_ch.valid   = 1'b0;
    in_ch.func    = 1'b0;
    in_ch.in_byte = 8'h00;
    rst_n         = 1'b0;
    errors        = 0;
    items_sent    = 0;
    idle_bursts   = 1'b0;
    stall_bursts  = 1'b0;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    clear_scan();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (DirectedRows[i])
      send_item(DirectedRows[i].eoi, DirectedRows[i].c, DirectedRows[i].pinned,
                DirectedRows[i].tok);
    wait_drained();

    idle_bursts  = 1'b1;
    stall_bursts = 1'b1;
    // blank run long enough to saturate the count
    send_pair(300);
    while (items_sent < TotalItems) begin
      if (!hold_done && items_sent >= 500) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= 1000) begin
        wait_drained();
        pause_done = 1'b1;
      end
      if (items_sent >= TotalItems - QuietTail) begin
        idle_bursts  = 1'b0;
        stall_bursts = 1'b0;
      end
      send_line();
    end

    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: key_value_line_tokenizer.f
src/kvt_pkg.sv
src/kvt_if.sv
src/kvt_front.sv
src/kvt_back.sv
src/key_value_line_tokenizer.sv
src/kvt_checker.sv
bench/tb_top.sv
